FILE: sv/energy_turn_scheduler_core_defines.svh
// Assertion macros for the turn scheduler
`ifndef ENERGY_TURN_SCHEDULER_CORE_DEFINES_SVH
`define ENERGY_TURN_SCHEDULER_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define ETS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ETS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ETS_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define ETS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

FILE: sv/ets_pkg.sv
// ----------------------------------------------------------------------------
// ets_pkg
// Types and codes shared by the turn scheduler modules.
// ----------------------------------------------------------------------------
`default_nettype none
package ets_pkg;
    typedef enum logic [2:0] {
        FN_ENQUEUE = 3'd0, FN_REMOVE = 3'd1, FN_NEXT = 3'd2, FN_REQUEUE = 3'd3,
        FN_GET_ENERGY = 3'd4, FN_CONTAINS = 3'd5, FN_IS_EMPTY = 3'd6,
        FN_SNAPSHOT = 3'd7
    } t_func;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_DUPLICATE = 3'd1;
    localparam logic [2:0] ST_NOT_QUEUED = 3'd2;
    localparam logic [2:0] ST_EMPTY     = 3'd3;
    localparam logic [2:0] ST_FULL      = 3'd4;

    localparam int MAX_RESULTS = 16;
    localparam logic [14:0] THRESHOLD_RESET = 15'd100;

    typedef struct packed {
        logic [2:0]         func;
        logic [31:0]        actor_id;
        logic signed [15:0] energy;
    } t_in_item;

    typedef struct packed {
        logic [2:0]         status;
        logic [31:0]        result_id;
        logic signed [31:0] current_energy;
        logic [31:0]        ticks_until_ready;
        logic               flag;
        logic               last;
    } t_out_item;

    typedef struct packed {
        logic [31:0]        id;
        logic signed [15:0] start_energy;
        logic [31:0]        stamp_time;
        logic [31:0]        sequence_num;
    } t_entry;

    function automatic logic [31:0] f_ready(input t_entry e, input logic [14:0] thr);
        logic signed [17:0] need;
        logic [32:0]        sum;
        need = $signed({3'b000, thr}) - 18'($signed(e.start_energy));
        if (need < 0) begin
            need = '0;
        end
        sum = {1'b0, e.stamp_time} + 33'(unsigned'(need));
        return sum[32] ? 32'hFFFF_FFFF : sum[31:0];
    endfunction

    function automatic logic [31:0] f_energy(input t_entry e, input logic [31:0] gt);
        logic signed [34:0] v;
        v = 35'($signed(e.start_energy)) + $signed({3'b000, gt})
            - $signed({3'b000, e.stamp_time});
        if (v > 35'sd2147483647) begin
            return 32'h7FFF_FFFF;
        end else if (v < -35'sd2147483648) begin
            return 32'h8000_0000;
        end
        return v[31:0];
    endfunction
endpackage
`default_nettype wire

FILE: sv/ets_entry_ram.sv
// ----------------------------------------------------------------------------
// ets_entry_ram
// Entry table: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none
module ets_entry_ram import ets_pkg::*; #(
    parameter int CAPACITY = 16
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_we,
    input  wire logic [$clog2(CAPACITY)-1:0] i_waddr,
    input  wire t_entry                      i_wdata,
    input  wire logic [$clog2(CAPACITY)-1:0] i_raddr,
    output t_entry                           o_rdata
);
    t_entry r_mem [CAPACITY];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

FILE: sv/energy_turn_scheduler_core.sv
// ----------------------------------------------------------------------------
// energy_turn_scheduler_core
// Energy-based turn scheduler over a table of actor entries.
// ----------------------------------------------------------------------------
// Usage: items enter on i_in_valid/o_in_ready as a t_in_item; results leave
// on o_out_valid/i_out_ready as t_out_item, last set on the final one. The
// threshold is written through i_cfg_valid/o_cfg_ready while idle and no
// item is offered.
// One item is handled at a time. Each item scans the entry memory one slot
// per cycle (one read port, registered data). Next, get_energy and snapshot
// add a read-back of the chosen entry before each result is built; the next
// input is taken once the result is in the output register. Snapshot scans
// again for each result listed, up to 16 results, waiting on transfers.
// Each result is held in an output register until transferred; a stalled
// receiver holds the block before the next result is built. Reset clears
// valid bits, time and sequence and sets the threshold to THRESHOLD_RESET;
// no clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none
`include "energy_turn_scheduler_core_defines.svh"
module energy_turn_scheduler_core import ets_pkg::*; #(
    parameter int CAPACITY = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire t_in_item    i_in_data,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output t_out_item        o_out_data,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [14:0] i_cfg_data
);
    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int RW = $clog2(MAX_RESULTS + 1);

    typedef enum logic [2:0] {S_IDLE, S_SCAN, S_DECIDE, S_READ, S_EMIT, S_OUT} t_state;

    t_state           r_state, n_state;
    t_in_item         r_item;
    logic [CAPACITY-1:0] r_valid, r_used;
    logic [14:0]      r_thr;
    logic [31:0]      r_gtime, r_nseq;
    logic [CW-1:0]    r_cnt;
    logic [AW-1:0]    r_rd_idx;
    logic             r_found, r_has_free, r_has_best;
    logic [AW-1:0]    r_found_slot, r_free_slot, r_best_slot;
    logic [31:0]      r_found_seq;
    logic [31:0]      r_best_ready, r_best_seq;
    logic [RW-1:0]    r_nout;
    t_out_item        r_out, n_out;
    logic             r_out_valid, n_out_valid;

    logic             we;
    logic [AW-1:0]    waddr, raddr;
    t_entry           wdata, rdata;

    ets_entry_ram #(.CAPACITY(CAPACITY)) u_ram (
        .i_clk(i_clk), .i_we(we), .i_waddr(waddr), .i_wdata(wdata),
        .i_raddr(raddr), .o_rdata(rdata)
    );

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = (r_state == S_IDLE) && !i_in_valid;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    logic        scan_live;
    logic [31:0] rd_ready;
    logic        rd_cand, rd_better;
    logic        cnt_top;
    logic        out_hold;

    assign out_hold = r_out_valid && !i_out_ready;

    always_comb begin
        cnt_top   = (r_cnt == CW'(CAPACITY));
        raddr     = (r_state == S_IDLE) ? '0
                  : (r_state == S_DECIDE || r_state == S_READ) ? r_best_slot
                  : AW'(r_cnt);
        scan_live = (r_state == S_SCAN) && (r_cnt != '0);
        rd_ready  = f_ready(rdata, r_thr);
        rd_cand   = r_valid[r_rd_idx] && !r_used[r_rd_idx];
        rd_better = !r_has_best || (rd_ready < r_best_ready)
                  || (rd_ready == r_best_ready && rdata.sequence_num < r_best_seq);
        we    = 1'b0;
        waddr = r_found_slot;
        wdata = rdata;
        if (r_state == S_DECIDE && !out_hold) begin
            if (r_item.func == FN_ENQUEUE && !r_found && r_has_free) begin
                we    = 1'b1;
                waddr = r_free_slot;
                wdata = '{id: r_item.actor_id, start_energy: r_item.energy,
                          stamp_time: r_gtime, sequence_num: r_nseq};
            end else if (r_item.func == FN_REQUEUE && r_found) begin
                we    = 1'b1;
                wdata = '{id: r_item.actor_id, start_energy: r_item.energy,
                          stamp_time: r_gtime, sequence_num: r_found_seq};
            end
        end
    end

    always_comb begin
        n_state     = r_state;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (cnt_top) begin
                    n_state = S_DECIDE;
                end
            end
            S_DECIDE: begin
                if (!out_hold) begin
                    n_out = '{status: ST_OK, result_id: '0, current_energy: '0,
                              ticks_until_ready: '0, flag: 1'b0, last: 1'b1};
                    n_state = S_OUT;
                    unique case (r_item.func)
                        FN_ENQUEUE: begin
                            if (r_found) n_out.status = ST_DUPLICATE;
                            else if (!r_has_free) n_out.status = ST_FULL;
                        end
                        FN_REMOVE, FN_REQUEUE: begin
                            if (!r_found) n_out.status = ST_NOT_QUEUED;
                        end
                        FN_CONTAINS: n_out.flag = r_found;
                        FN_IS_EMPTY: n_out.flag = (r_valid == '0);
                        FN_GET_ENERGY: begin
                            if (!r_found) n_out.status = ST_NOT_QUEUED;
                            else n_state = S_READ;
                        end
                        FN_NEXT, FN_SNAPSHOT: begin
                            if (!r_has_best) begin
                                if (r_nout == '0) n_out.status = ST_EMPTY;
                                else n_state = S_IDLE;
                            end else begin
                                n_state = S_READ;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_READ: n_state = S_EMIT;
            S_EMIT: begin
                n_out = '{status: ST_OK, result_id: '0,
                          current_energy: f_energy(rdata, r_gtime),
                          ticks_until_ready: '0, flag: 1'b0, last: 1'b1};
                if (r_item.func != FN_GET_ENERGY) begin
                    n_out.result_id = rdata.id;
                    n_out.ticks_until_ready = (r_best_ready > r_gtime)
                                            ? r_best_ready - r_gtime : '0;
                end
                if (r_item.func == FN_SNAPSHOT) begin
                    n_out.last = (r_nout == RW'(MAX_RESULTS - 1))
                               || ((r_valid & ~r_used & ~(CAPACITY'(1) << r_best_slot))
                                   == '0);
                end
                n_state = S_OUT;
            end
            S_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    n_out_valid = 1'b1;
                    if (r_item.func == FN_SNAPSHOT && !r_out.last) begin
                        n_state = S_SCAN;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_valid     <= '0;
            r_thr       <= THRESHOLD_RESET;
            r_gtime     <= '0;
            r_nseq      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out       <= n_out;
            r_out_valid <= n_out_valid;
            unique case (r_state)
                S_IDLE: begin
                    if (i_cfg_valid && o_cfg_ready) begin
                        r_thr <= i_cfg_data;
                    end
                    if (i_in_valid) begin
                        r_item     <= i_in_data;
                        r_used     <= '0;
                        r_nout     <= '0;
                        r_cnt      <= '0;
                        r_found    <= 1'b0;
                        r_has_free <= 1'b0;
                        r_has_best <= 1'b0;
                    end
                end
                S_SCAN: begin
                    // slot r_rd_idx data arrives this cycle
                    if (scan_live) begin
                        if (r_valid[r_rd_idx] && rdata.id == r_item.actor_id) begin
                            r_found      <= 1'b1;
                            r_found_slot <= r_rd_idx;
                            r_found_seq  <= rdata.sequence_num;
                        end
                        if (!r_valid[r_rd_idx] && !r_has_free) begin
                            r_has_free  <= 1'b1;
                            r_free_slot <= r_rd_idx;
                        end
                        if (rd_cand && rd_better) begin
                            r_has_best   <= 1'b1;
                            r_best_slot  <= r_rd_idx;
                            r_best_ready <= rd_ready;
                            r_best_seq   <= rdata.sequence_num;
                        end
                    end
                    r_rd_idx <= AW'(r_cnt);
                    r_cnt    <= r_cnt + 1'b1;
                end
                S_DECIDE: begin
                    if (!out_hold) begin
                        unique case (r_item.func)
                            FN_ENQUEUE: begin
                                if (!r_found && r_has_free) begin
                                    r_valid[r_free_slot] <= 1'b1;
                                    r_nseq <= r_nseq + 32'd1;
                                end
                            end
                            FN_REMOVE: begin
                                if (r_found) r_valid[r_found_slot] <= 1'b0;
                            end
                            FN_GET_ENERGY: begin
                                if (r_found) r_best_slot <= r_found_slot;
                            end
                            FN_NEXT: begin
                                if (r_has_best) r_gtime <= r_best_ready;
                            end
                            default: ;
                        endcase
                    end
                end
                S_EMIT: begin
                    if (r_item.func == FN_SNAPSHOT) begin
                        r_used[r_best_slot] <= 1'b1;
                        r_nout <= r_nout + 1'b1;
                    end
                end
                S_OUT: begin
                    if ((!r_out_valid || i_out_ready)
                        && r_item.func == FN_SNAPSHOT && !r_out.last) begin
                        r_cnt      <= '0;
                        r_has_best <= 1'b0;
                    end
                end
                default: ;
            endcase
        end
    end

    `ETS_ASSERT_IMPL(a_idle_ready, i_clk, i_rst_n, o_in_ready, r_state == S_IDLE)
    `ETS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_hold, o_out_valid && $stable(o_out_data))
    `ETS_ASSERT_IMPL(a_one_write, i_clk, i_rst_n, we, r_state == S_DECIDE)
    `ETS_ASSERT_NEXT(a_accept_scan, i_clk, i_rst_n, i_in_valid && o_in_ready, r_state == S_SCAN)
endmodule
`default_nettype wire
